/* src/cdta_pkg.sv */
package cdta_pkg;

    localparam int YEAR_BITS = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_ADD = 1'b1;

    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HOUR_PER_DAY = 5'd24;
    localparam logic [3:0] MONTH_PER_YR = 4'd12;
    localparam logic [4:0] MAX_DAY_ADD  = 5'd27;
    localparam logic [3:0] MAX_MON_ADD  = 4'd11;

    localparam logic [4:0] MONTH_SHORT = 5'd28;
    localparam logic [4:0] MONTH_MID   = 5'd30;
    localparam logic [4:0] MONTH_LONG  = 5'd31;

    localparam logic [5:0]           RST_SECOND = 6'd0;
    localparam logic [5:0]           RST_MINUTE = 6'd0;
    localparam logic [4:0]           RST_HOUR   = 5'd0;
    localparam logic [4:0]           RST_DAY    = 5'd1;
    localparam logic [3:0]           RST_MONTH  = 4'd1;
    localparam logic [YEAR_BITS-1:0] RST_YEAR   = YEAR_BITS'(2000);

    // One classified transaction as it waits between the front and back parts.
    typedef struct packed {
        logic                 is_add;
        logic                 rejected;
        logic [5:0]           sec;
        logic [5:0]           min;
        logic [4:0]           hour;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
    } t_cmd;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = MONTH_MID;
            4'd2:                    len = MONTH_SHORT;
            default:                 len = MONTH_LONG;
        endcase
        return len;
    endfunction

endpackage

/* src/cdta_if.sv */
interface cdta_in_if import cdta_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [5:0]           sec_value;
    logic [5:0]           min_value;
    logic [4:0]           hour_value;
    logic [4:0]           day_value;
    logic [3:0]           month_value;
    logic [YEAR_BITS-1:0] year_value;

    modport source (
        output valid, func, sec_value, min_value, hour_value, day_value,
               month_value, year_value,
        input  ready
    );
    modport sink (
        input  valid, func, sec_value, min_value, hour_value, day_value,
               month_value, year_value,
        output ready
    );
endinterface

interface cdta_out_if import cdta_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [5:0]           out_second;
    logic [5:0]           out_minute;
    logic [4:0]           out_hour;
    logic [4:0]           out_day;
    logic [3:0]           out_month;
    logic [YEAR_BITS-1:0] out_year;
    logic                 rejected;
    logic                 year_overflow;

    modport source (
        output valid, out_second, out_minute, out_hour, out_day, out_month,
               out_year, rejected, year_overflow,
        input  ready
    );
    modport sink (
        input  valid, out_second, out_minute, out_hour, out_day, out_month,
               out_year, rejected, year_overflow,
        output ready
    );
endinterface

/* src/cdta_front.sv */
module cdta_front import cdta_pkg::*; (
    cdta_in_if.sink i_in,
    input  logic    i_q_ready,
    output logic    o_q_valid,
    output t_cmd    o_q_cmd
);

    logic set_ok;
    logic add_ok;

    // Validation does not depend on the stored date, so it is done on entry.
    always_comb begin
        set_ok = (i_in.month_value >= 4'd1) && (i_in.month_value <= MONTH_PER_YR) &&
                 (i_in.day_value >= 5'd1) &&
                 (i_in.day_value <= month_len(i_in.month_value)) &&
                 (i_in.hour_value < HOUR_PER_DAY) &&
                 (i_in.min_value < MIN_PER_HOUR) &&
                 (i_in.sec_value < SEC_PER_MIN);
        add_ok = (i_in.day_value <= MAX_DAY_ADD) &&
                 (i_in.month_value <= MAX_MON_ADD) &&
                 (i_in.hour_value < HOUR_PER_DAY) &&
                 (i_in.min_value < MIN_PER_HOUR) &&
                 (i_in.sec_value < SEC_PER_MIN);
    end

    always_comb begin
        o_q_cmd.is_add   = (i_in.func == FUNC_ADD);
        o_q_cmd.rejected = (i_in.func == FUNC_ADD) ? !add_ok : !set_ok;
        o_q_cmd.sec      = i_in.sec_value;
        o_q_cmd.min      = i_in.min_value;
        o_q_cmd.hour     = i_in.hour_value;
        o_q_cmd.day      = i_in.day_value;
        o_q_cmd.month    = i_in.month_value;
        o_q_cmd.year     = i_in.year_value;
    end

    assign o_q_valid  = i_in.valid;
    assign i_in.ready = i_q_ready;

endmodule

/* src/cdta_queue.sv */
module cdta_queue import cdta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   push;
    logic                   pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* src/cdta_back.sv */
module cdta_back import cdta_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    output logic     o_q_ready,
    input  t_cmd     i_q_cmd,
    cdta_out_if.source o_out
);

    logic [5:0]           r_sec, r_min;
    logic [4:0]           r_hour, r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;

    logic                 r_out_valid;
    logic [5:0]           r_out_sec, r_out_min;
    logic [4:0]           r_out_hour, r_out_day;
    logic [3:0]           r_out_month;
    logic [YEAR_BITS-1:0] r_out_year;
    logic                 r_out_rej, r_out_ovf;

    logic [5:0]           n_sec, n_min;
    logic [4:0]           n_hour, n_day;
    logic [3:0]           n_month;
    logic [YEAR_BITS-1:0] n_year;
    logic                 n_ovf;

    logic [6:0]           s_sum, m_sum;
    logic [5:0]           h_sum, d_sum;
    logic [4:0]           mo_sum;
    logic [YEAR_BITS:0]   y_sum;
    logic                 c_sec, c_min, c_hour, c_day, c_mon;
    logic [4:0]           cur_len, new_len;
    logic [5:0]           d_wrap;
    logic                 pop;

    assign o_q_ready = !r_out_valid || o_out.ready;
    assign pop       = i_q_valid && o_q_ready;

    // Add chain: each field wraps at most once and carries one upward.
    always_comb begin
        s_sum   = {1'b0, r_sec} + {1'b0, i_q_cmd.sec};
        c_sec   = (s_sum >= {1'b0, SEC_PER_MIN});
        n_sec   = c_sec ? 6'(s_sum - {1'b0, SEC_PER_MIN}) : s_sum[5:0];

        m_sum   = {1'b0, r_min} + {1'b0, i_q_cmd.min} + 7'(c_sec);
        c_min   = (m_sum >= {1'b0, MIN_PER_HOUR});
        n_min   = c_min ? 6'(m_sum - {1'b0, MIN_PER_HOUR}) : m_sum[5:0];

        h_sum   = {1'b0, r_hour} + {1'b0, i_q_cmd.hour} + 6'(c_min);
        c_hour  = (h_sum >= {1'b0, HOUR_PER_DAY});
        n_hour  = c_hour ? 5'(h_sum - {1'b0, HOUR_PER_DAY}) : h_sum[4:0];

        cur_len = month_len(r_month);
        d_sum   = {1'b0, r_day} + {1'b0, i_q_cmd.day} + 6'(c_hour);
        c_day   = (d_sum > {1'b0, cur_len});
        d_wrap  = c_day ? (d_sum - {1'b0, cur_len}) : d_sum;

        mo_sum  = {1'b0, r_month} + {1'b0, i_q_cmd.month} + 5'(c_day);
        c_mon   = (mo_sum > {1'b0, MONTH_PER_YR});
        n_month = c_mon ? 4'(mo_sum - {1'b0, MONTH_PER_YR}) : mo_sum[3:0];

        // A day past the end of the new month is pulled back to its last day.
        new_len = month_len(n_month);
        n_day   = (d_wrap > {1'b0, new_len}) ? new_len : d_wrap[4:0];

        y_sum   = {1'b0, r_year} + {1'b0, i_q_cmd.year} + (YEAR_BITS + 1)'(c_mon);
        n_ovf   = y_sum[YEAR_BITS];
        n_year  = n_ovf ? '1 : y_sum[YEAR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= RST_SECOND;
            r_min       <= RST_MINUTE;
            r_hour      <= RST_HOUR;
            r_day       <= RST_DAY;
            r_month     <= RST_MONTH;
            r_year      <= RST_YEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop && !i_q_cmd.rejected) begin
                if (i_q_cmd.is_add) begin
                    r_sec   <= n_sec;
                    r_min   <= n_min;
                    r_hour  <= n_hour;
                    r_day   <= n_day;
                    r_month <= n_month;
                    r_year  <= n_year;
                end else begin
                    r_sec   <= i_q_cmd.sec;
                    r_min   <= i_q_cmd.min;
                    r_hour  <= i_q_cmd.hour;
                    r_day   <= i_q_cmd.day;
                    r_month <= i_q_cmd.month;
                    r_year  <= i_q_cmd.year;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_rej <= i_q_cmd.rejected;
            if (i_q_cmd.rejected) begin
                r_out_sec   <= r_sec;
                r_out_min   <= r_min;
                r_out_hour  <= r_hour;
                r_out_day   <= r_day;
                r_out_month <= r_month;
                r_out_year  <= r_year;
                r_out_ovf   <= 1'b0;
            end else if (i_q_cmd.is_add) begin
                r_out_sec   <= n_sec;
                r_out_min   <= n_min;
                r_out_hour  <= n_hour;
                r_out_day   <= n_day;
                r_out_month <= n_month;
                r_out_year  <= n_year;
                r_out_ovf   <= n_ovf;
            end else begin
                r_out_sec   <= i_q_cmd.sec;
                r_out_min   <= i_q_cmd.min;
                r_out_hour  <= i_q_cmd.hour;
                r_out_day   <= i_q_cmd.day;
                r_out_month <= i_q_cmd.month;
                r_out_year  <= i_q_cmd.year;
                r_out_ovf   <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_second    = r_out_sec;
    assign o_out.out_minute    = r_out_min;
    assign o_out.out_hour      = r_out_hour;
    assign o_out.out_day       = r_out_day;
    assign o_out.out_month     = r_out_month;
    assign o_out.out_year      = r_out_year;
    assign o_out.rejected      = r_out_rej;
    assign o_out.year_overflow = r_out_ovf;

endmodule

/* src/calendar_datetime_adder_unit.sv */
// Stored date-time with set and add transactions on a fixed 365-day calendar.
// Every input transaction yields exactly one result: the stored fields after
// the step, a rejected flag for an invalid set or an out-of-range offset, and
// a year_overflow flag when an add saturates the year. One transaction is
// accepted per clock cycle while the queue has room and the output side is
// not stalled. An accepted transaction is first written into the queue; the
// back part then pops it and loads its result into the output register,
// from which it can be taken. That throughput is set by the back part,
// which runs the whole seconds-to-years carry chain against the stored
// date combinationally. A two-entry queue between validation and the back
// part, plus the output register, lets either side stall independently.
module calendar_datetime_adder_unit import cdta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdta_in_if.sink     i_in,
    cdta_out_if.source  o_out
);

    logic q_push_valid;
    logic q_push_ready;
    t_cmd q_push_cmd;
    logic q_pop_valid;
    logic q_pop_ready;
    t_cmd q_pop_cmd;

    cdta_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_push_ready),
        .o_q_valid (q_push_valid),
        .o_q_cmd   (q_push_cmd)
    );

    cdta_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_cmd   (q_push_cmd),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_cmd    (q_pop_cmd)
    );

    cdta_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_pop_valid),
        .o_q_ready (q_pop_ready),
        .i_q_cmd   (q_pop_cmd),
        .o_out     (o_out)
    );

endmodule
